FILE: hw/rtl/pulse_height_histogram_macros.svh
// ----------------------------------------------------------------------------
// Pulse height histogram assertion macros
// Shared concurrent assertion forms, clocked on i_clk and off during reset.
// ----------------------------------------------------------------------------
`ifndef PULSE_HEIGHT_HISTOGRAM_MACROS_SVH
`define PULSE_HEIGHT_HISTOGRAM_MACROS_SVH

`ifndef NO_ASSERTIONS

`define PHH_ASSERT_SAME(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("pulse height histogram: same-cycle check failed");

`define PHH_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("pulse height histogram: next-cycle check failed");

`else

`define PHH_ASSERT_SAME(lbl, ante, cons)

`define PHH_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

FILE: hw/rtl/phh_pkg.sv
// ----------------------------------------------------------------------------
// Pulse height histogram package
// Widths, codes, defaults and the item types passed between the parts.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package phh_pkg;

    localparam int AMP_W    = 12;
    localparam int BIN_W    = 12;
    localparam int SAMPLE_W = 12;
    localparam int COUNT_W  = 16;
    localparam int RES_W    = 2;

    localparam int DEFAULT_HEADER_WORDS = 0;
    localparam int DEFAULT_MAX_BINS     = 4096;
    localparam int QUEUE_DEPTH          = 2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    localparam logic [RES_W-1:0] RES_1024 = 2'd0;
    localparam logic [RES_W-1:0] RES_2048 = 2'd1;
    localparam logic [RES_W-1:0] RES_4096 = 2'd2;

    typedef enum logic [1:0] {
        BK_CLEAR,
        BK_IDLE,
        BK_UPDATE
    } t_back_state;

    typedef struct packed {
        logic                counted;
        logic [BIN_W-1:0]    bin;
        logic [SAMPLE_W-1:0] temperature;
        logic [SAMPLE_W-1:0] voltage;
    } t_cmd;

    typedef struct packed {
        logic [BIN_W-1:0]    bin_index;
        logic [COUNT_W-1:0]  bin_count;
        logic                bin_saturated;
        logic [SAMPLE_W-1:0] held_temperature;
        logic [SAMPLE_W-1:0] held_voltage;
    } t_result;

endpackage

FILE: hw/rtl/phh_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phh_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hw/rtl/phh_fifo.sv
// ----------------------------------------------------------------------------
// Pulse height histogram queue
// Small first-in first-out buffer that decouples two handshake sides.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phh_fifo #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_wr_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_rd_data,
    output logic             o_empty
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count, n_count;
    logic             do_push, do_pop;

    assign o_full    = (r_count == CW'(DEPTH));
    assign o_empty   = (r_count == '0);
    assign do_push   = i_push && !o_full;
    assign do_pop    = i_pop && !o_empty;
    assign o_rd_data = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        n_rd_ptr = (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        case ({do_push, do_pop})
            2'b10: begin
                n_count = r_count + 1'b1;
            end
            2'b01: begin
                n_count = r_count - 1'b1;
            end
            default: begin
                n_count = r_count;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= n_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= n_rd_ptr;
            end
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_wr_data;
        end
    end

endmodule

FILE: hw/rtl/phh_front.sv
// ----------------------------------------------------------------------------
// Pulse height histogram front end
// Accepts items, maps the amplitude to a bin and tracks the held samples.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phh_front
    import phh_pkg::*;
#(
    parameter int MAX_BINS = DEFAULT_MAX_BINS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RES_W-1:0]    i_cfg_data,
    input  logic                i_push,
    output logic                o_full,
    input  logic [AMP_W-1:0]    i_pulse_amplitude,
    input  logic [SAMPLE_W-1:0] i_temperature_sample,
    input  logic [SAMPLE_W-1:0] i_voltage_sample,
    input  logic                i_capture_request,
    input  logic                i_clearing,
    input  logic                i_cmd_full,
    output logic                o_cmd_push,
    output t_cmd                o_cmd
);

    logic [RES_W-1:0]    r_bin_resolution;
    logic [SAMPLE_W-1:0] r_temperature, n_temperature;
    logic [SAMPLE_W-1:0] r_voltage, n_voltage;
    logic [BIN_W-1:0]    raw_bin;
    logic                counted;
    logic                accept;

    assign o_cfg_ready = 1'b1;
    assign o_full      = i_clearing || i_cmd_full;
    assign accept      = i_push && !o_full;
    assign o_cmd_push  = accept;

    always_comb begin
        counted = 1'b1;
        case (r_bin_resolution)
            RES_1024: begin
                raw_bin = {2'b00, i_pulse_amplitude[AMP_W-1:2]};
            end
            RES_2048: begin
                raw_bin = {1'b0, i_pulse_amplitude[AMP_W-1:1]};
            end
            RES_4096: begin
                raw_bin = i_pulse_amplitude;
            end
            default: begin
                raw_bin = '0;
                counted = 1'b0;
            end
        endcase

        n_temperature = i_capture_request ? i_temperature_sample : r_temperature;
        n_voltage     = i_capture_request ? i_voltage_sample : r_voltage;

        o_cmd.counted     = counted;
        o_cmd.bin         = ({1'b0, raw_bin} >= (BIN_W + 1)'(MAX_BINS))
                            ? BIN_W'(MAX_BINS - 1) : raw_bin;
        o_cmd.temperature = n_temperature;
        o_cmd.voltage     = n_voltage;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_resolution <= RES_1024;
            r_temperature    <= '0;
            r_voltage        <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_bin_resolution <= i_cfg_data;
            end
            if (accept) begin
                r_temperature <= n_temperature;
                r_voltage     <= n_voltage;
            end
        end
    end

endmodule

FILE: hw/rtl/phh_back.sv
// ----------------------------------------------------------------------------
// Pulse height histogram back end
// Clears the spectrum after reset, then runs one read-modify-write per item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module phh_back
    import phh_pkg::*;
#(
    parameter int HEADER_WORDS = DEFAULT_HEADER_WORDS,
    parameter int MAX_BINS     = DEFAULT_MAX_BINS
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    output logic    o_clearing,
    input  logic    i_cmd_empty,
    input  t_cmd    i_cmd,
    output logic    o_cmd_pop,
    input  logic    i_res_full,
    output logic    o_res_push,
    output t_result o_res
);

    localparam int STORE_WORDS = HEADER_WORDS + MAX_BINS;
    localparam int AW          = $clog2(STORE_WORDS);
    localparam int CLR_W       = $clog2(MAX_BINS);

    t_back_state        r_state, n_state;
    logic [CLR_W-1:0]   r_clr_idx;
    t_cmd               r_cmd;
    logic               ram_we;
    logic [AW-1:0]      ram_waddr, ram_raddr;
    logic [COUNT_W-1:0] ram_wdata, ram_rdata;
    logic               saturated;

    phh_ram #(
        .WIDTH(COUNT_W),
        .DEPTH(STORE_WORDS)
    ) u_spectrum (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign o_clearing = (r_state == BK_CLEAR);
    assign ram_raddr  = AW'(HEADER_WORDS) + AW'(i_cmd.bin);
    assign saturated  = (ram_rdata == COUNT_MAX);

    always_comb begin
        n_state    = r_state;
        o_cmd_pop  = 1'b0;
        o_res_push = 1'b0;
        ram_we     = 1'b0;
        ram_waddr  = AW'(HEADER_WORDS) + AW'(r_cmd.bin);
        ram_wdata  = ram_rdata + 1'b1;

        o_res.bin_index        = r_cmd.bin;
        o_res.bin_count        = r_cmd.counted ? (saturated ? ram_rdata : ram_wdata) : '0;
        o_res.bin_saturated    = r_cmd.counted && saturated;
        o_res.held_temperature = r_cmd.temperature;
        o_res.held_voltage     = r_cmd.voltage;

        case (r_state)
            BK_CLEAR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(HEADER_WORDS) + AW'(r_clr_idx);
                ram_wdata = '0;
                if (r_clr_idx == CLR_W'(MAX_BINS - 1)) begin
                    n_state = BK_IDLE;
                end
            end
            BK_IDLE: begin
                if (!i_cmd_empty && !i_res_full) begin
                    o_cmd_pop = 1'b1;
                    n_state   = BK_UPDATE;
                end
            end
            BK_UPDATE: begin
                ram_we     = r_cmd.counted && !saturated;
                o_res_push = 1'b1;
                n_state    = BK_IDLE;
            end
            default: begin
                n_state = BK_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= BK_CLEAR;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == BK_CLEAR) begin
                r_clr_idx <= r_clr_idx + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_cmd_pop) begin
            r_cmd <= i_cmd;
        end
    end

endmodule

FILE: hw/rtl/pulse_height_histogram.sv
// ----------------------------------------------------------------------------
// Pulse height histogram
// Multichannel analyzer binning of pulse amplitudes into a 16-bit spectrum.
// ----------------------------------------------------------------------------
// Items enter through push/full: an item is taken when push is high and full
// is low. Each item yields one result on the result ports, shown while empty
// is low and taken when pop is high. The resolution register is written on
// the configuration channel when i_cfg_valid and o_cfg_ready are both high;
// o_cfg_ready is always high. The user must write the register only while the
// block is idle; the block itself does not enforce this. After reset the
// spectrum memory is cleared one bin per cycle over all MAX_BINS bins; full
// stays high until the pass ends. An item passes the command queue, the update
// engine and the result queue. The spectrum memory needs a read and a write
// for each item, so the update engine takes no new item until it has written
// back the last. Two-entry queues sit between the input side, the update
// engine and the result side; when the receiver stalls, results collect in
// the output queue, then items in the command queue; full rises once both fill.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "pulse_height_histogram_macros.svh"

module pulse_height_histogram
    import phh_pkg::*;
#(
    parameter int HEADER_WORDS = DEFAULT_HEADER_WORDS,
    parameter int MAX_BINS     = DEFAULT_MAX_BINS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [RES_W-1:0]    i_cfg_data,
    input  logic                push,
    output logic                full,
    input  logic [AMP_W-1:0]    i_pulse_amplitude,
    input  logic [SAMPLE_W-1:0] i_temperature_sample,
    input  logic [SAMPLE_W-1:0] i_voltage_sample,
    input  logic                i_capture_request,
    output logic                empty,
    input  logic                pop,
    output logic [BIN_W-1:0]    o_bin_index,
    output logic [COUNT_W-1:0]  o_bin_count,
    output logic                o_bin_saturated,
    output logic [SAMPLE_W-1:0] o_held_temperature,
    output logic [SAMPLE_W-1:0] o_held_voltage
);

    logic    clearing;
    logic    cmd_push, cmd_full, cmd_empty, cmd_pop;
    t_cmd    cmd_in, cmd_head;
    logic    res_push, res_full;
    t_result res_in, res_head;

    phh_front #(
        .MAX_BINS(MAX_BINS)
    ) u_front (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_data          (i_cfg_data),
        .i_push              (push),
        .o_full              (full),
        .i_pulse_amplitude   (i_pulse_amplitude),
        .i_temperature_sample(i_temperature_sample),
        .i_voltage_sample    (i_voltage_sample),
        .i_capture_request   (i_capture_request),
        .i_clearing          (clearing),
        .i_cmd_full          (cmd_full),
        .o_cmd_push          (cmd_push),
        .o_cmd               (cmd_in)
    );

    phh_fifo #(
        .WIDTH($bits(t_cmd)),
        .DEPTH(QUEUE_DEPTH)
    ) u_cmd_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (cmd_push),
        .i_wr_data(cmd_in),
        .o_full   (cmd_full),
        .i_pop    (cmd_pop),
        .o_rd_data(cmd_head),
        .o_empty  (cmd_empty)
    );

    phh_back #(
        .HEADER_WORDS(HEADER_WORDS),
        .MAX_BINS    (MAX_BINS)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .o_clearing (clearing),
        .i_cmd_empty(cmd_empty),
        .i_cmd      (cmd_head),
        .o_cmd_pop  (cmd_pop),
        .i_res_full (res_full),
        .o_res_push (res_push),
        .o_res      (res_in)
    );

    phh_fifo #(
        .WIDTH($bits(t_result)),
        .DEPTH(QUEUE_DEPTH)
    ) u_res_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (res_push),
        .i_wr_data(res_in),
        .o_full   (res_full),
        .i_pop    (pop),
        .o_rd_data(res_head),
        .o_empty  (empty)
    );

    assign o_bin_index        = res_head.bin_index;
    assign o_bin_count        = res_head.bin_count;
    assign o_bin_saturated    = res_head.bin_saturated;
    assign o_held_temperature = res_head.held_temperature;
    assign o_held_voltage     = res_head.held_voltage;

    `PHH_ASSERT_SAME(a_clear_blocks_input, clearing, full)
    `PHH_ASSERT_SAME(a_cmd_push_has_room, cmd_push, !cmd_full)
    `PHH_ASSERT_SAME(a_res_push_has_room, res_push, !res_full)
    `PHH_ASSERT_NEXT(a_pop_then_update, cmd_pop, res_push && !cmd_pop)
    `PHH_ASSERT_SAME(a_saturated_count, !empty && o_bin_saturated, o_bin_count == COUNT_MAX)

endmodule

FILE: sim/pulse_height_histogram_tb.sv
// ----------------------------------------------------------------------------
// Pulse height histogram testbench
// Sends pulse items through the push/full side and keeps its own spectrum,
// sample latches and resolution setting to predict each result. The result
// side is checked field by field against the oldest prediction. The run covers
// every resolution code and random traffic with the sender and the receiver
// idling in several patterns.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pulse_height_histogram_tb;

    import phh_pkg::*;

    localparam logic [RES_W-1:0] RES_UNUSED = 2'd3;

    localparam int SPECTRUM_BINS     = DEFAULT_MAX_BINS;
    localparam int ITEMS_PER_PHASE   = 94;
    localparam int WATCHDOG_LIMIT    = 20000;
    localparam int END_SETTLE_CYCLES = 12;

    typedef struct {
        logic [AMP_W-1:0]    amplitude;
        logic [SAMPLE_W-1:0] temperature;
        logic [SAMPLE_W-1:0] voltage;
        logic                capture;
    } t_pulse;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                i_cfg_valid = 1'b0;
    logic                o_cfg_ready;
    logic [RES_W-1:0]    i_cfg_data = '0;
    logic                push = 1'b0;
    logic                full;
    logic [AMP_W-1:0]    i_pulse_amplitude = '0;
    logic [SAMPLE_W-1:0] i_temperature_sample = '0;
    logic [SAMPLE_W-1:0] i_voltage_sample = '0;
    logic                i_capture_request = 1'b0;
    logic                empty;
    logic                pop = 1'b0;
    logic [BIN_W-1:0]    o_bin_index;
    logic [COUNT_W-1:0]  o_bin_count;
    logic                o_bin_saturated;
    logic [SAMPLE_W-1:0] o_held_temperature;
    logic [SAMPLE_W-1:0] o_held_voltage;

    t_pulse              pulses_to_send [$];
    t_result             expected_results [$];
    logic [RES_W-1:0]    resolution_writes [$];

    logic [COUNT_W-1:0]  spectrum_model [SPECTRUM_BINS];
    logic [SAMPLE_W-1:0] temperature_held;
    logic [SAMPLE_W-1:0] voltage_held;
    logic [RES_W-1:0]    resolution_model;

    int                  pulses_queued = 0;
    int                  pulses_accepted = 0;
    int                  resolution_writes_done = 0;
    int                  send_idle_pct = 0;
    int                  recv_stall_pct = 0;
    int                  failures = 0;
    int                  quiet_cycles = 0;

    pulse_height_histogram dut (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cfg_valid          (i_cfg_valid),
        .o_cfg_ready          (o_cfg_ready),
        .i_cfg_data           (i_cfg_data),
        .push                 (push),
        .full                 (full),
        .i_pulse_amplitude    (i_pulse_amplitude),
        .i_temperature_sample (i_temperature_sample),
        .i_voltage_sample     (i_voltage_sample),
        .i_capture_request    (i_capture_request),
        .empty                (empty),
        .pop                  (pop),
        .o_bin_index          (o_bin_index),
        .o_bin_count          (o_bin_count),
        .o_bin_saturated      (o_bin_saturated),
        .o_held_temperature   (o_held_temperature),
        .o_held_voltage       (o_held_voltage)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    task automatic count_pulse(input t_pulse pulse);
        t_result          res;
        logic [BIN_W-1:0] bin_no;
        res = '0;
        bin_no = '0;
        case (resolution_model)
            RES_1024: begin
                bin_no = {2'b00, pulse.amplitude[AMP_W-1:2]};
            end
            RES_2048: begin
                bin_no = {1'b0, pulse.amplitude[AMP_W-1:1]};
            end
            RES_4096: begin
                bin_no = pulse.amplitude;
            end
            default: begin
                bin_no = '0;
            end
        endcase
        if (resolution_model != RES_UNUSED) begin
            res.bin_index = bin_no;
            if (spectrum_model[bin_no] == COUNT_MAX) begin
                res.bin_saturated = 1'b1;
            end else begin
                spectrum_model[bin_no] = spectrum_model[bin_no] + 1'b1;
            end
            res.bin_count = spectrum_model[bin_no];
        end
        if (pulse.capture) begin
            temperature_held = pulse.temperature;
            voltage_held = pulse.voltage;
        end
        res.held_temperature = temperature_held;
        res.held_voltage = voltage_held;
        expected_results.push_back(res);
    endtask

    function automatic void check_field(input string field, input logic [COUNT_W-1:0] want,
                                        input logic [COUNT_W-1:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            failures++;
        end
    endfunction

    task automatic queue_pulse(input logic [AMP_W-1:0] amplitude,
                               input logic [SAMPLE_W-1:0] temperature,
                               input logic [SAMPLE_W-1:0] voltage, input logic capture);
        t_pulse pulse;
        pulse.amplitude = amplitude;
        pulse.temperature = temperature;
        pulse.voltage = voltage;
        pulse.capture = capture;
        pulses_to_send.push_back(pulse);
        pulses_queued++;
    endtask

    task automatic wait_until_idle();
        while (pulses_accepted != pulses_queued || expected_results.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_resolution(input logic [RES_W-1:0] code);
        int target;
        target = resolution_writes_done + 1;
        resolution_writes.push_back(code);
        while (resolution_writes_done < target) begin
            @(posedge i_clk);
        end
    endtask

    always @(posedge i_clk) begin : pulse_driver
        t_pulse next_pulse;
        if (!i_rst_n) begin
            push <= 1'b0;
        end else begin
            if (push && !full) begin
                next_pulse.amplitude = i_pulse_amplitude;
                next_pulse.temperature = i_temperature_sample;
                next_pulse.voltage = i_voltage_sample;
                next_pulse.capture = i_capture_request;
                count_pulse(next_pulse);
                pulses_accepted++;
            end
            if (!push || !full) begin
                if (pulses_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    next_pulse = pulses_to_send.pop_front();
                    i_pulse_amplitude <= next_pulse.amplitude;
                    i_temperature_sample <= next_pulse.temperature;
                    i_voltage_sample <= next_pulse.voltage;
                    i_capture_request <= next_pulse.capture;
                    push <= 1'b1;
                end else begin
                    push <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        t_result want;
        if (!i_rst_n) begin
            pop <= 1'b0;
        end else begin
            if (pop && !empty) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result: bin_index %0d, bin_count %0d",
                           o_bin_index, o_bin_count);
                    failures++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("bin_index", COUNT_W'(want.bin_index),
                                COUNT_W'(o_bin_index));
                    check_field("bin_count", want.bin_count, o_bin_count);
                    check_field("bin_saturated", COUNT_W'(want.bin_saturated),
                                COUNT_W'(o_bin_saturated));
                    check_field("held_temperature", COUNT_W'(want.held_temperature),
                                COUNT_W'(o_held_temperature));
                    check_field("held_voltage", COUNT_W'(want.held_voltage),
                                COUNT_W'(o_held_voltage));
                end
            end
            pop <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    always @(posedge i_clk) begin : resolution_port
        logic             next_valid;
        logic [RES_W-1:0] next_data;
        if (!i_rst_n) begin
            i_cfg_valid <= 1'b0;
        end else begin
            next_valid = i_cfg_valid;
            next_data = i_cfg_data;
            if (i_cfg_valid && o_cfg_ready) begin
                resolution_model = i_cfg_data;
                resolution_writes_done++;
                next_valid = 1'b0;
            end
            if (!next_valid && resolution_writes.size() != 0) begin
                next_valid = 1'b1;
                next_data = resolution_writes.pop_front();
            end
            i_cfg_valid <= next_valid;
            i_cfg_data <= next_data;
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [RES_W-1:0] phase_codes [8];
        int               send_modes [4];
        int               recv_modes [4];
        logic [AMP_W-1:0] hot_amps [8];
        logic [AMP_W-1:0] amp;
        int               roll;

        phase_codes = '{RES_1024, RES_4096, RES_2048, RES_UNUSED,
                        RES_4096, RES_1024, RES_2048, RES_UNUSED};
        send_modes = '{0, 81, 0, 13};
        recv_modes = '{0, 0, 81, 13};
        for (int b = 0; b < SPECTRUM_BINS; b++) begin
            spectrum_model[b] = '0;
        end
        temperature_held = '0;
        voltage_held = '0;
        resolution_model = RES_1024;

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset resolution: 1024 bins.
        queue_pulse(12'hFFF, 12'h000, 12'hFFF, 1'b0);
        queue_pulse(12'h000, 12'hFFF, 12'h000, 1'b1);
        queue_pulse(12'h003, 12'h000, 12'hFFF, 1'b1);
        queue_pulse(12'hFFC, 12'hAAA, 12'h555, 1'b0);
        wait_until_idle();

        set_resolution(RES_4096);
        queue_pulse(12'h000, 12'hAAA, 12'h555, 1'b1);
        queue_pulse(12'hFFF, 12'h555, 12'hAAA, 1'b1);
        queue_pulse(12'hFFF, 12'h123, 12'h456, 1'b0);
        queue_pulse(12'hAAA, 12'hFFF, 12'hFFF, 1'b1);
        queue_pulse(12'h555, 12'h000, 12'h000, 1'b1);
        wait_until_idle();

        set_resolution(RES_2048);
        queue_pulse(12'h001, 12'h000, 12'h000, 1'b0);
        queue_pulse(12'h000, 12'h7FF, 12'h800, 1'b1);
        queue_pulse(12'hFFF, 12'h000, 12'h000, 1'b0);
        queue_pulse(12'hFFE, 12'h001, 12'hFFE, 1'b1);
        wait_until_idle();

        set_resolution(RES_UNUSED);
        queue_pulse(12'hFFF, 12'hFFF, 12'h000, 1'b1);
        queue_pulse(12'h000, 12'h000, 12'hFFF, 1'b0);
        queue_pulse(12'h800, 12'h800, 12'h7FF, 1'b1);
        wait_until_idle();

        for (int phase = 0; phase < 8; phase++) begin
            set_resolution(phase_codes[phase]);
            send_idle_pct = send_modes[phase % 4];
            recv_stall_pct = recv_modes[phase % 4];
            for (int h = 0; h < 8; h++) begin
                hot_amps[h] = AMP_W'($urandom_range(4095));
            end
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                roll = $urandom_range(99);
                if (roll < 40) begin
                    amp = AMP_W'($urandom_range(4095));
                end else if (roll < 85) begin
                    amp = hot_amps[3'($urandom_range(7))];
                end else begin
                    amp = ($urandom_range(1) != 0) ? 12'hFFF : 12'h000;
                end
                queue_pulse(amp, SAMPLE_W'($urandom_range(4095)),
                            SAMPLE_W'($urandom_range(4095)),
                            $urandom_range(99) < 35);
            end
            wait_until_idle();
        end

        repeat (END_SETTLE_CYCLES) @(posedge i_clk);
        if (failures == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
